### design/nsmp_pkg.sv
// ----------------------------------------------------------------------------
// nsmp_pkg
// Shared codes and widths for the nibble-serial mouse port.
// ----------------------------------------------------------------------------
package nsmp_pkg;

    localparam int OP_W  = 2;
    localparam int POS_W = 9;
    localparam int BYTE_W = 8;

    // Item operations
    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_STROBE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // Nibble sequence phases
    localparam logic [1:0] PH_XHI = 2'd0;
    localparam logic [1:0] PH_XLO = 2'd1;
    localparam logic [1:0] PH_YHI = 2'd2;
    localparam logic [1:0] PH_YLO = 2'd3;

    localparam int STROBE_BIT = 4;

    localparam logic [BYTE_W-1:0] TIMEOUT_RST  = 8'd196;
    localparam logic [BYTE_W-1:0] STROBE_RST   = 8'hFF;
    localparam logic [BYTE_W-1:0] IDLE_DATA    = 8'hFF;
    localparam logic [BYTE_W-1:0] READ_PRESSED = 8'hE0;
    localparam logic [2:0]        READ_TOP     = 3'b111;

endpackage

### design/nibble_serial_mouse_port_core.sv
// ----------------------------------------------------------------------------
// nibble_serial_mouse_port_core
// Mouse side of a nibble-serial port: strobe writes step a four-phase nibble
// sequence over latched movement deltas, reads return it, ticks run a timeout.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | opcode, strobe, pos x/y, button
//  out     | output    | o_out_valid / i_out_ready  | port_data
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_wdata = timeout_cycles
//
// One item per cycle while the result is not stalled; each item passes the
// input register, then the result register. All state updates in one pass of
// logic between those two registers. A stalled result holds the result
// register; an empty input register takes one more beat before ready drops.
// Reset is synchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module nibble_serial_mouse_port_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [nsmp_pkg::OP_W-1:0]     i_opcode,
    input  logic [nsmp_pkg::BYTE_W-1:0]   i_strobe_value,
    input  logic [nsmp_pkg::POS_W-1:0]    i_pos_x,
    input  logic [nsmp_pkg::POS_W-1:0]    i_pos_y,
    input  logic                          i_right_button,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nsmp_pkg::BYTE_W-1:0]   o_port_data,
    input  logic                          i_cfg_we,
    input  logic [nsmp_pkg::BYTE_W-1:0]   i_cfg_wdata
);
    import nsmp_pkg::*;

    // Input register
    logic              r_s1_valid;
    logic [OP_W-1:0]   r_s1_op;
    logic              r_s1_strobe;
    logic [BYTE_W-1:0] r_s1_strobe_value;
    logic [BYTE_W-1:0] r_s1_x8;
    logic [BYTE_W-1:0] r_s1_y8;
    logic              r_s1_button;

    // Result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;

    // Block state
    logic [BYTE_W-1:0] r_timeout_cycles;
    logic [1:0]        r_phase;
    logic [BYTE_W-1:0] r_prev_strobe;
    logic [BYTE_W-1:0] r_delta_x;
    logic [BYTE_W-1:0] r_delta_y;
    logic [BYTE_W-1:0] r_last_x;
    logic [BYTE_W-1:0] r_last_y;
    logic [BYTE_W-1:0] r_tcount;

    logic              adv;
    logic              is_read;
    logic              restart;
    logic              edge_seen;
    logic              was_high;
    logic              latch;
    logic [1:0]        n_phase;
    logic [BYTE_W-1:0] n_prev_strobe;
    logic [BYTE_W-1:0] n_delta_x;
    logic [BYTE_W-1:0] n_delta_y;
    logic [BYTE_W-1:0] n_last_x;
    logic [BYTE_W-1:0] n_last_y;
    logic [BYTE_W-1:0] n_tcount;
    logic [3:0]        nib;
    logic [BYTE_W-1:0] n_out_data;

    assign adv         = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || adv;
    assign o_out_valid = r_out_valid;
    assign o_port_data = r_out_data;

    assign is_read   = (r_s1_op == OP_READ);
    assign restart   = is_read && (r_phase != PH_XHI) && (r_tcount == '0);
    assign was_high  = r_prev_strobe[STROBE_BIT];
    assign edge_seen = (r_s1_op == OP_STROBE) && (r_s1_strobe != was_high);
    assign latch     = restart || (edge_seen && (r_phase == PH_YLO) && was_high);

    always_comb begin
        n_phase       = r_phase;
        n_prev_strobe = r_prev_strobe;
        n_tcount      = r_tcount;
        if (restart) begin
            n_phase = PH_XHI;
        end
        if (edge_seen) begin
            n_tcount      = r_timeout_cycles;
            n_prev_strobe = r_s1_strobe_value;
            // advance on rising edges into odd phases, falling into even ones
            unique case (r_phase)
                PH_XHI: if (r_s1_strobe) n_phase = PH_XLO;
                PH_XLO: if (was_high)    n_phase = PH_YHI;
                PH_YHI: if (r_s1_strobe) n_phase = PH_YLO;
                PH_YLO: if (was_high)    n_phase = PH_XHI;
                default: n_phase = r_phase;
            endcase
        end
        if ((r_s1_op == OP_TICK) && (r_tcount != '0)) begin
            n_tcount = r_tcount - 8'd1;
        end
    end

    always_comb begin
        n_delta_x = r_delta_x;
        n_delta_y = r_delta_y;
        n_last_x  = r_last_x;
        n_last_y  = r_last_y;
        if (latch) begin
            n_delta_x = r_last_x - r_s1_x8;
            n_delta_y = r_s1_y8 - r_last_y;
            n_last_x  = r_s1_x8;
            n_last_y  = r_s1_y8;
        end
    end

    always_comb begin
        unique case (n_phase)
            PH_XHI:  nib = n_delta_x[7:4];
            PH_XLO:  nib = n_delta_x[3:0];
            PH_YHI:  nib = n_delta_y[7:4];
            PH_YLO:  nib = n_delta_y[3:0];
            default: nib = n_delta_y[3:0];
        endcase
        if (!is_read) begin
            n_out_data = IDLE_DATA;
        end else if (r_s1_button) begin
            n_out_data = READ_PRESSED;
        end else begin
            n_out_data = {READ_TOP, 1'b1, nib};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1_op           <= i_opcode;
            r_s1_strobe       <= i_strobe_value[STROBE_BIT];
            r_s1_strobe_value <= i_strobe_value;
            r_s1_x8           <= i_pos_x[POS_W-1:1];
            r_s1_y8           <= i_pos_y[POS_W-1:1];
            r_s1_button       <= i_right_button;
        end
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_timeout_cycles <= TIMEOUT_RST;
            r_phase          <= PH_YLO;
            r_prev_strobe    <= STROBE_RST;
            r_delta_x        <= '0;
            r_delta_y        <= '0;
            r_last_x         <= '0;
            r_last_y         <= '0;
            r_tcount         <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_timeout_cycles <= i_cfg_wdata;
            end
            if (adv) begin
                r_phase       <= n_phase;
                r_prev_strobe <= n_prev_strobe;
                r_delta_x     <= n_delta_x;
                r_delta_y     <= n_delta_y;
                r_last_x      <= n_last_x;
                r_last_y      <= n_last_y;
                r_tcount      <= n_tcount;
            end
        end
    end

    a_idle_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !is_read) |=> (o_port_data == IDLE_DATA))
        else $error("non-read beat did not return idle data");

    a_read_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_read) |=> (o_port_data[7:5] == READ_TOP))
        else $error("read beat lost its top bits");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && restart) |=> (r_phase == PH_XHI))
        else $error("timed-out read did not restart the sequence");

    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_s1_op == OP_TICK) && (r_tcount != '0))
            |=> (r_tcount == $past(r_tcount) - 8'd1))
        else $error("tick did not count the timer down");

endmodule
